// ----- hw/rtl/tkr_pkg.sv -----
`default_nettype none

package tkr_pkg;

  // table shape and field widths
  localparam int DEPTH_DEF = 10;
  localparam int ID_W      = 16;
  localparam int SIZE_W    = 16;
  localparam int CMD_W     = 2;
  localparam int RANK_W    = 4;

  // command codes, code 3 is unused, leaves the table as is and answers a miss
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  // one command word as held in the input stage
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   entry_id;
    logic [SIZE_W-1:0] network_size;
  } req_t;

  // answer of the table for one command
  typedef struct packed {
    logic              found;
    logic [RANK_W-1:0] rank;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tkr_ifs.sv -----
`default_nettype none

// command channel
interface tkr_req_if;
  logic                      valid;
  logic                      ready;
  logic [tkr_pkg::CMD_W-1:0]  command;
  logic [tkr_pkg::ID_W-1:0]   entry_id;
  logic [tkr_pkg::SIZE_W-1:0] network_size;

  modport source (output valid, command, entry_id, network_size, input ready);
  modport sink   (input valid, command, entry_id, network_size, output ready);
endinterface

// result channel
interface tkr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [tkr_pkg::RANK_W-1:0] rank;

  modport source (output valid, found, rank, input ready);
  modport sink   (input valid, found, rank, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tkr_table.sv -----
`default_nettype none

module tkr_table #(
  parameter int DEPTH = tkr_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire tkr_pkg::req_t req,
  output tkr_pkg::res_t      res
);
  import tkr_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ID_W-1:0]   ids   [DEPTH];
  logic [SIZE_W-1:0] sizes [DEPTH];

  logic [DEPTH-1:0]   gt_hits;
  logic [DEPTH-1:0]   id_hits;
  logic [DEPTH-1:0]   ins_first;
  logic [DEPTH-1:0]   ins_ge;
  logic [DEPTH-1:0]   id_first;
  logic [IDX_W-1:0]   ins_idx;
  logic [IDX_W-1:0]   id_idx;
  logic [IDX_W+RANK_W-1:0] rank_ext;
  logic               is_add;
  logic               is_clear;
  logic               is_lookup;

  assign is_clear  = (req.command == CMD_CLEAR);
  assign is_add    = (req.command == CMD_ADD);
  assign is_lookup = (req.command == CMD_LOOKUP);

  // per-entry compares against the incoming word
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt_hits[i] = (req.network_size > sizes[i]);
      id_hits[i] = (ids[i] == req.entry_id);
    end
  end

  // isolate first hit; ranks at or past the insert point shift down
  assign ins_first = gt_hits & (~gt_hits + DEPTH'(1));
  assign id_first  = id_hits & (~id_hits + DEPTH'(1));
  assign ins_ge    = ~(ins_first - DEPTH'(1));

  // one-hot to index
  always_comb begin
    ins_idx = '0;
    id_idx  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_first[i]) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
      if (id_first[i]) begin
        id_idx = id_idx | IDX_W'(i);
      end
    end
  end

  // result, rank wraps to its field width
  always_comb begin
    res.found = 1'b0;
    rank_ext  = '0;
    if (is_add) begin
      res.found = |gt_hits;
      rank_ext  = {{RANK_W{1'b0}}, ins_idx};
    end else if (is_lookup) begin
      res.found = |id_hits;
      rank_ext  = {{RANK_W{1'b0}}, id_idx};
    end
    res.rank = rank_ext[RANK_W-1:0];
  end

  // table update: clear, or insert with shift down
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ids[i]   <= '0;
        sizes[i] <= '0;
      end
    end else if (fire && is_clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        ids[i]   <= '0;
        sizes[i] <= '0;
      end
    end else if (fire && is_add) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ins_first[i]) begin
          ids[i]   <= req.entry_id;
          sizes[i] <= req.network_size;
        end else if (ins_ge[i] && i > 0) begin
          ids[i]   <= ids[(i > 0) ? i - 1 : 0];
          sizes[i] <= sizes[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/top_k_ranked_id_table.sv -----
// a command word passes the input register, then its result the result register
// throughput: one command word per cycle while results are not held back, set by the
//   single table update done between the input register and the result register
// while a result waits, a word in the input stage is held there
// reset (synchronous, active high) zeroes every table entry and empties both stages
`default_nettype none

module top_k_ranked_id_table #(
  parameter int DEPTH = tkr_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  tkr_req_if.sink   req,
  tkr_rsp_if.source rsp
);
  import tkr_pkg::*;

  logic s1_valid;
  req_t s1_req;
  logic out_valid;
  res_t out_res;
  res_t tbl_res;
  logic advance;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req.command      <= req.command;
      s1_req.entry_id     <= req.entry_id;
      s1_req.network_size <= req.network_size;
    end
  end

  // ranked table, updated as the word leaves the input stage
  tkr_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (s1_req),
    .res  (tbl_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= tbl_res;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.found = out_res.found;
  assign rsp.rank  = out_res.rank;

  // a miss always reports rank zero
  a_miss_rank_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.found |-> out_res.rank == '0)
    else $error("miss with nonzero rank");

  // a clear leaving the input stage yields a miss
  a_clear_miss: assert property (@(posedge clk) disable iff (rst)
    advance && s1_req.command == CMD_CLEAR |=> out_valid && !out_res.found)
    else $error("clear reported a hit");

  // input stalls only when both stages are held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && out_valid && !rsp.ready)
    else $error("input stalled without backpressure");

endmodule

`default_nettype wire
